// File: design/hsw_pkg.sv
// ----------------------------------------------------------------------------
// hsw_pkg: shared types and constants of the heartbeat stall watchdog
// Event kinds, judgement codes, register indexes and the result record that
// moves from the front end through the queue to the output stage.
// ----------------------------------------------------------------------------
package hsw_pkg;

    // Event kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_HEARTBEAT = 2'd0,
        MODE_CHECK     = 2'd1,
        MODE_START     = 2'd2
    } t_mode;

    // Judgement of one check
    typedef enum logic [2:0] {
        ST_DISABLED  = 3'd0,
        ST_PROGRESS  = 3'd1,
        ST_FORGIVEN  = 3'd2,
        ST_CONFIRM   = 3'd3,
        ST_OVERDUE   = 3'd4,
        ST_EARLYWARN = 3'd5,
        ST_HEALTHY   = 3'd6
    } t_status;

    // Configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 16;
    typedef logic [CFG_AW-1:0] t_cfg_addr;
    localparam t_cfg_addr CFG_DEADLINE = 1'b0;
    localparam t_cfg_addr CFG_ENABLE   = 1'b1;

    // Deadline arithmetic: max(reg, 5) * 1000 fits in 26 bits
    localparam int              DL_W         = 26;
    localparam logic [CFG_DW-1:0] MIN_DEADLINE_S = 16'd5;
    localparam logic [DL_W-1:0] MS_PER_S     = 26'd1000;
    localparam logic [DL_W-1:0] RESET_DL_MS  = 26'd5000;

    // Field widths
    localparam int LAG_W   = 32;
    localparam int TICK_W  = 8;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;
    localparam int OUT_W   = 48;

    // One result record
    typedef struct packed {
        logic [LAG_W-1:0]  lag_ms;
        t_status           status;
        logic              notify_alive;
        logic              resumed;
        logic              first_warning;
        logic              abort_fire;
        logic [TICK_W-1:0] stale_ticks;
    } t_result;

    // Output tdata bit positions
    localparam int OB_STATUS = 32;
    localparam int OB_FIRE   = 38;

endpackage

// File: design/hsw_front.sv
// ----------------------------------------------------------------------------
// hsw_front: event intake and stall judgement
// Accepts one event a cycle while the queue is not full, updates the watchdog
// state and pushes one result record into the queue for every check event.
// ----------------------------------------------------------------------------
module hsw_front
    import hsw_pkg::*;
#(
    parameter int CONFIRM_TICKS = 3,
    parameter int TIME_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_time_ms,
    input  logic              i_cfg_we,
    input  t_cfg_addr         i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_q_full,
    output logic              o_push,
    output t_result           o_push_data
);

    localparam int CMP_W = (TIME_WIDTH > DL_W) ? TIME_WIDTH : DL_W;
    localparam logic [TICK_W-1:0] CONFIRM = TICK_W'(CONFIRM_TICKS);

    logic [DL_W-1:0]       r_limit_ms;
    logic                  r_enabled;
    logic [TIME_WIDTH-1:0] r_hb_time,  n_hb_time;
    logic [TIME_WIDTH-1:0] r_chk_time, n_chk_time;
    logic                  r_chk_seen, n_chk_seen;
    logic                  r_pending,  n_pending;
    logic [TICK_W-1:0]     r_over,     n_over;
    logic                  r_forgiven, n_forgiven;
    logic                  r_warned,   n_warned;
    logic                  r_aborted,  n_aborted;

    logic                  w_accept;
    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_lag;
    logic [TIME_WIDTH-1:0] w_gap;
    logic [CMP_W-1:0]      w_lag_x, w_gap_x, w_dl_x, w_half_x;
    logic [TICK_W-1:0]     w_over_inc;
    logic [CFG_DW-1:0]     w_secs;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    assign w_now   = TIME_WIDTH'(i_time_ms);
    assign w_lag   = w_now - r_hb_time;
    assign w_gap   = r_chk_seen ? (w_now - r_chk_time) : '0;
    assign w_lag_x = CMP_W'(w_lag);
    assign w_gap_x = CMP_W'(w_gap);
    assign w_dl_x  = CMP_W'(r_limit_ms);
    assign w_half_x = CMP_W'(r_limit_ms >> 1);

    assign w_over_inc = (r_over != TICK_MAX) ? r_over + 1'b1 : r_over;
    assign w_secs     = (i_cfg_wdata < MIN_DEADLINE_S) ? MIN_DEADLINE_S : i_cfg_wdata;

    // Configuration: fold the clamp and the seconds-to-ms scale in at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_ms <= RESET_DL_MS;
            r_enabled  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_DEADLINE) begin
                r_limit_ms <= DL_W'(DL_W'(w_secs) * MS_PER_S);
            end
            if (i_cfg_addr == CFG_ENABLE) begin
                r_enabled <= i_cfg_wdata[0];
            end
        end
    end

    always_comb begin
        n_hb_time   = r_hb_time;
        n_chk_time  = r_chk_time;
        n_chk_seen  = r_chk_seen;
        n_pending   = r_pending;
        n_over      = r_over;
        n_forgiven  = r_forgiven;
        n_warned    = r_warned;
        n_aborted   = r_aborted;
        o_push      = 1'b0;
        o_push_data = '0;
        o_push_data.lag_ms = LAG_W'(w_lag);
        o_push_data.status = ST_DISABLED;

        if (w_accept) begin
            unique case (t_mode'(i_mode))
                MODE_HEARTBEAT: begin
                    n_hb_time = w_now;
                    n_pending = 1'b1;
                end
                MODE_START: begin
                    n_hb_time = w_now;
                end
                MODE_CHECK: begin
                    o_push = 1'b1;
                    if (r_enabled) begin
                        n_chk_time = w_now;
                        n_chk_seen = 1'b1;
                        if (r_pending) begin
                            n_pending  = 1'b0;
                            n_over     = '0;
                            n_forgiven = 1'b0;
                            n_warned   = 1'b0;
                            o_push_data.resumed      = r_warned;
                            o_push_data.notify_alive = 1'b1;
                            o_push_data.status       = ST_PROGRESS;
                        end else if (w_gap_x > w_dl_x && !r_forgiven) begin
                            // observer itself was away: forgive once per stall
                            n_forgiven = 1'b1;
                            n_over     = '0;
                            o_push_data.status = ST_FORGIVEN;
                        end else if (w_lag_x > w_dl_x) begin
                            n_over = w_over_inc;
                            if (w_over_inc < CONFIRM) begin
                                o_push_data.status = ST_CONFIRM;
                            end else begin
                                o_push_data.status = ST_OVERDUE;
                                if (!r_aborted) begin
                                    n_aborted = 1'b1;
                                    o_push_data.abort_fire = 1'b1;
                                end
                            end
                        end else if (w_lag_x > w_half_x) begin
                            if (!r_warned) begin
                                n_warned = 1'b1;
                                o_push_data.first_warning = 1'b1;
                            end
                            o_push_data.status = ST_EARLYWARN;
                        end else begin
                            o_push_data.notify_alive = 1'b1;
                            o_push_data.status       = ST_HEALTHY;
                        end
                    end
                    o_push_data.stale_ticks = n_over;
                end
                default: begin
                    // unused kind: drop the event
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb_time  <= '0;
            r_chk_time <= '0;
            r_chk_seen <= 1'b0;
            r_pending  <= 1'b0;
            r_over     <= '0;
            r_forgiven <= 1'b0;
            r_warned   <= 1'b0;
            r_aborted  <= 1'b0;
        end else begin
            r_hb_time  <= n_hb_time;
            r_chk_time <= n_chk_time;
            r_chk_seen <= n_chk_seen;
            r_pending  <= n_pending;
            r_over     <= n_over;
            r_forgiven <= n_forgiven;
            r_warned   <= n_warned;
            r_aborted  <= n_aborted;
        end
    end

endmodule

// File: design/hsw_queue.sv
// ----------------------------------------------------------------------------
// hsw_queue: two-entry result queue
// Decouples the front end from the output stage so either side can stall.
// ----------------------------------------------------------------------------
module hsw_queue
    import hsw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_not_empty,
    output t_result o_head
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_head      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/hsw_back.sv
// ----------------------------------------------------------------------------
// hsw_back: output register stage
// Pulls result records from the queue and presents them as output beats.
// ----------------------------------------------------------------------------
module hsw_back
    import hsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_not_empty,
    input  t_result          i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data
);

    logic    r_valid;
    t_result r_data;

    // Load when the register is empty or its beat leaves this cycle
    assign o_pop   = i_not_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = {1'b0, r_data.stale_ticks, r_data.abort_fire, r_data.first_warning,
                      r_data.resumed, r_data.notify_alive, r_data.status, r_data.lag_ms};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: design/heartbeat_stall_watchdog.sv
// ----------------------------------------------------------------------------
// heartbeat_stall_watchdog: heartbeat stall watchdog
// Watches a worker through timestamped heartbeat, start and check events and
// judges each check as disabled, progress, forgiven, healthy, warning, confirming or overdue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: s_axis beats, event kind on tuser (heartbeat, check,
//   start), the millisecond timestamp on tdata. Heartbeat and start beats
//   give no output; every check beat gives exactly one output beat.
//   Output channel: m_axis beats carry lag, judgement, the one-shot flags and
//   the stale tick count, packed as listed at the port.
//   Config: write i_cfg_wdata to register i_cfg_addr when i_cfg_we is high
//   (0: deadline in seconds, 1: enable). Write only while no check is in
//   flight. The clamp to 5 s and the ms scaling happen at write time.
//   Timing: the block takes one beat per cycle while the queue is not full.
//   A check passes through the queue and then the output register; the
//   combinational judgement in the front end sets the rate, since each event
//   must see the state the previous one left behind.
//   Stall: when m_axis_tready is low, the output register holds its beat and
//   the two-entry queue behind it fills; s_axis_tready drops once the queue
//   is full and rises as soon as one entry leaves.
//   Reset: synchronous, active low. All watchdog state clears, the deadline
//   returns to 5 s, judgement is disabled and no output beat is pending.
// ----------------------------------------------------------------------------
module heartbeat_stall_watchdog
    import hsw_pkg::*;
#(
    parameter int CONFIRM_TICKS = 3,
    parameter int TIME_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input events
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [31:0] time_ms
    input  logic [1:0]        s_axis_tuser,   // [1:0] mode
    // Check results
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [31:0] lag_ms, [34:32] status,
                                              // [35] notify_alive, [36] resumed,
                                              // [37] first_warning, [38] abort_fire,
                                              // [46:39] stale_ticks, [47] zero
    // Configuration writes
    input  logic              i_cfg_we,
    input  t_cfg_addr         i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    logic    w_push;
    t_result w_push_data;
    logic    w_q_full;
    logic    w_pop;
    logic    w_not_empty;
    t_result w_head;

    // Front end: classify each event and update the watchdog state
    hsw_front #(
        .CONFIRM_TICKS (CONFIRM_TICKS),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_time_ms   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Queue: absorb results while the receiver stalls
    hsw_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_head      (w_head)
    );

    // Back end: registered output beats
    hsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (w_not_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule

// File: design/hsw_checker.sv
// ----------------------------------------------------------------------------
// hsw_checker: port-level checks for the heartbeat stall watchdog
// Watches the top-level ports and flags ordering and one-shot violations.
// ----------------------------------------------------------------------------
module hsw_checker
    import hsw_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [1:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic       w_in_chk;
    logic       w_out_beat;
    logic [3:0] r_inflight;
    logic       r_fired;

    assign w_in_chk   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_CHECK);
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // Count checks accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_fired    <= 1'b0;
        end else begin
            r_inflight <= r_inflight + 4'(w_in_chk) - 4'(w_out_beat);
            if (w_out_beat && m_axis_tdata[OB_FIRE]) begin
                r_fired <= 1'b1;
            end
        end
    end

    // Every output beat answers an earlier check
    a_no_spurious_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> r_inflight != 4'd0)
        else $error("output beat with no check in flight");

    // Abort fires at most once per reset
    a_abort_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_beat && r_fired) |-> !m_axis_tdata[OB_FIRE])
        else $error("abort fired twice");

    // Abort comes only with the overdue judgement
    a_abort_overdue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[OB_FIRE]) |->
        (m_axis_tdata[OB_STATUS +: 3] == ST_OVERDUE))
        else $error("abort without overdue status");

    // Reset leaves no beat pending
    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A stalled beat holds
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output beat changed");

endmodule

bind heartbeat_stall_watchdog hsw_checker u_hsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
